/* rtl/core/cir_pkg.sv */
// Package: types, codes and arithmetic helpers for the contact impulse resolver.
package cir_pkg;

	// Configuration register indexes
	localparam logic [7:0] REG_RESTITUTION    = 8'd0;
	localparam logic [7:0] REG_BULLET_DAMPING = 8'd1;
	localparam logic [15:0] RESTITUTION_RESET    = 16'd0;
	localparam logic [15:0] BULLET_DAMPING_RESET = 16'd3277;

	// Mode and outcome codes
	localparam logic MODE_IMPULSE  = 1'b0;
	localparam logic MODE_POSITION = 1'b1;
	localparam logic [1:0] OUT_APPLIED    = 2'd0;
	localparam logic [1:0] OUT_SEPARATING = 2'd1;
	localparam logic [1:0] OUT_ZERO_MASS  = 2'd2;
	localparam logic [1:0] OUT_SATURATED  = 2'd3;

	// One quotient bit per divider stage
	localparam int DIV_STEPS = 31;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic        [30:0] penetration;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic        [30:0] inv_mass_a;
		logic        [30:0] inv_mass_b;
		logic               bullet_involved;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_a_x;
		logic signed [31:0] new_a_y;
		logic signed [31:0] new_b_x;
		logic signed [31:0] new_b_y;
		logic        [1:0]  outcome;
	} result_t;

	// Per-contact context carried down the pipe
	typedef struct packed {
		logic               mode;
		logic               bullet;
		logic        [1:0]  outcome;
		logic               clipped;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic        [30:0] ima;
		logic        [30:0] imb;
		logic        [31:0] sum;
	} ctx_t;

	// Divider stage contents
	typedef struct packed {
		ctx_t        ctx;
		logic [31:0] rem;
		logic [30:0] numlo;
		logic [30:0] quo;
		logic        jsat;
	} div_t;

	// Saturate to signed 32 bits; MSB of the return is the clip flag
	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > 66'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -66'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/core/contact_impulse_resolver.sv */
// Top level: config registers, pipeline control, front / divider / back chain.
// Stages from accepted item to result: 4 front, 31 restoring divider for j, 5 back.
// Throughput: one contact per cycle while not stalled; the divider sets the depth.
// A stall on the result side freezes every stage; nothing is dropped or repeated.
// Reset clears all valid bits, restitution to 0 and bullet damping to 3277.
module contact_impulse_resolver (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  cir_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output cir_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import cir_pkg::*;

	logic [15:0] restitution_q, bullet_damping_q;
	logic        en;
	logic        dv [DIV_STEPS+1];
	div_t        dd [DIV_STEPS+1];

	// Configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q    <= RESTITUTION_RESET;
			bullet_damping_q <= BULLET_DAMPING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESTITUTION:    restitution_q    <= cfg_data;
				REG_BULLET_DAMPING: bullet_damping_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole pipe advances unless the output holds a stalled transaction
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	cir_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.vin         (item_valid),
		.din         (item),
		.restitution (restitution_q),
		.vout        (dv[0]),
		.dout        (dd[0])
	);

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		cir_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (dv[g]),
			.din    (dd[g]),
			.vout   (dv[g+1]),
			.dout   (dd[g+1])
		);
	end

	cir_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vin     (dv[DIV_STEPS]),
		.din     (dd[DIV_STEPS]),
		.damping (bullet_damping_q),
		.vout    (result_valid),
		.dout    (result)
	);

endmodule

/* rtl/core/cir_front.sv */
// Front stages: relative normal velocity or position correction, impulse numerator.
module cir_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vin,
	input  cir_pkg::item_t din,
	input  logic [15:0]    restitution,
	output logic           vout,
	output cir_pkg::div_t  dout
);
	import cir_pkg::*;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	ctx_t               ctx_s1, ctx_s2, ctx_s3;
	logic signed [64:0] p0_s1, p1_s1;
	logic signed [31:0] vn_s2;
	logic        [48:0] num_s3;
	div_t               div_s4;

	logic signed [32:0] dx, dy, op0, op1, pen_s;
	ctx_t               ctx_in, ctx2;
	logic        [32:0] vn_sat, vx_sat, vy_sat;
	logic signed [65:0] vn_full;
	logic        [31:0] nv;
	logic        [16:0] factor;
	div_t               div_in;

	// Stage 1: products against the normal (velocity difference or depth)
	always_comb begin
		dx    = 33'(din.b_x) - 33'(din.a_x);
		dy    = 33'(din.b_y) - 33'(din.a_y);
		pen_s = $signed({2'b00, din.penetration});
		op0   = (din.mode == MODE_POSITION) ? pen_s : dx;
		op1   = (din.mode == MODE_POSITION) ? pen_s : dy;
		ctx_in = '0;
		ctx_in.mode   = din.mode;
		ctx_in.bullet = din.bullet_involved;
		ctx_in.a_x    = din.a_x;
		ctx_in.a_y    = din.a_y;
		ctx_in.b_x    = din.b_x;
		ctx_in.b_y    = din.b_y;
		ctx_in.nx     = din.normal_x;
		ctx_in.ny     = din.normal_y;
		ctx_in.ima    = din.inv_mass_a;
		ctx_in.imb    = din.inv_mass_b;
		ctx_in.sum    = {1'b0, din.inv_mass_a} + {1'b0, din.inv_mass_b};
	end

	// Stage 2: normal velocity, outcome classification, position correction
	always_comb begin
		vn_full = 66'(p0_s1 >>> 16) + 66'(p1_s1 >>> 16);
		vn_sat  = sat32(vn_full);
		vx_sat  = sat32(66'(p0_s1 >>> 16));
		vy_sat  = sat32(66'(p1_s1 >>> 16));
		ctx2    = ctx_s1;
		if (ctx_s1.mode == MODE_IMPULSE) begin
			ctx2.clipped = vn_sat[32];
			if ($signed(vn_sat[31:0]) > 32'sd0) begin
				ctx2.outcome = OUT_SEPARATING;
			end else if (ctx_s1.sum == 32'd0) begin
				ctx2.outcome = OUT_ZERO_MASS;
			end
		end else begin
			ctx2.vx      = vx_sat[31:0];
			ctx2.vy      = vy_sat[31:0];
			ctx2.clipped = vx_sat[32] | vy_sat[32];
			if (ctx_s1.sum == 32'd0) begin
				ctx2.outcome = OUT_ZERO_MASS;
			end
		end
	end

	// Stage 3: numerator (1 + e) * -vn
	always_comb begin
		nv     = 32'(-vn_s2);
		factor = 17'h10000 + 17'(restitution);
	end

	// Stage 4: divider setup and quotient overflow test
	always_comb begin
		div_in.ctx   = ctx_s3;
		div_in.rem   = {14'd0, num_s3[48:31]};
		div_in.numlo = num_s3[30:0];
		div_in.quo   = '0;
		div_in.jsat  = ({14'd0, num_s3[48:31]} >= ctx_s3.sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vin;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			p0_s1  <= 65'(op0) * 65'(din.normal_x);
			p1_s1  <= 65'(op1) * 65'(din.normal_y);
			ctx_s2 <= ctx2;
			vn_s2  <= vn_sat[31:0];
			ctx_s3 <= ctx_s2;
			num_s3 <= 49'(factor) * 49'(nv);
			div_s4 <= div_in;
		end
	end

	assign vout = valid_s4;
	assign dout = div_s4;

endmodule

/* rtl/core/cir_div_step.sv */
// One restoring-division stage: produces one quotient bit of j.
module cir_div_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  cir_pkg::div_t din,
	output logic          vout,
	output cir_pkg::div_t dout
);
	import cir_pkg::*;

	logic        valid_q;
	div_t        div_q;
	div_t        nxt;
	logic [32:0] r2;
	logic        ge;

	// Shift in next numerator bit, subtract divisor when it fits
	always_comb begin
		r2  = {din.rem, din.numlo[30]};
		ge  = (r2 >= {1'b0, din.ctx.sum});
		nxt = din;
		nxt.rem   = ge ? 32'(r2 - {1'b0, din.ctx.sum}) : r2[31:0];
		nxt.numlo = {din.numlo[29:0], 1'b0};
		nxt.quo   = {din.quo[29:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_q <= nxt;
		end
	end

	assign vout = valid_q;
	assign dout = div_q;

endmodule

/* rtl/core/cir_back.sv */
// Back stages: impulse vector, velocity/position update, bullet damping, result.
module cir_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vin,
	input  cir_pkg::div_t    din,
	input  logic [15:0]      damping,
	output logic             vout,
	output cir_pkg::result_t dout
);
	import cir_pkg::*;

	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	ctx_t               ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic signed [63:0] pa_s1, pb_s1;
	logic signed [63:0] max_s3, may_s3, mbx_s3, mby_s3;
	logic signed [31:0] r0_s4, r1_s4, r2_s4, r3_s4;
	result_t            res_s5;

	logic signed [31:0] j;
	ctx_t               ctx1, ctx2, ctx4;
	logic        [32:0] sx, sy, s0, s1, s2, s3;
	logic signed [31:0] ima_s, imb_s;
	logic signed [32:0] dmp;
	result_t            res;

	// Stage 1: j with saturation
	assign j = din.jsat ? 32'sh7FFF_FFFF : $signed({1'b0, din.quo});

	// Clipped quotient counts as saturation on the impulse path
	always_comb begin
		ctx1 = din.ctx;
		if (din.ctx.mode == MODE_IMPULSE && din.jsat) begin
			ctx1.clipped = 1'b1;
		end
	end

	// Stage 2: impulse components
	always_comb begin
		sx   = sat32(66'(pa_s1 >>> 16));
		sy   = sat32(66'(pb_s1 >>> 16));
		ctx2 = ctx_s1;
		if (ctx_s1.mode == MODE_IMPULSE && ctx_s1.outcome == OUT_APPLIED) begin
			ctx2.vx      = sx[31:0];
			ctx2.vy      = sy[31:0];
			ctx2.clipped = ctx_s1.clipped | sx[32] | sy[32];
		end
	end

	// Stage 3 operands: inverse masses as signed
	assign ima_s = $signed({1'b0, ctx_s2.ima});
	assign imb_s = $signed({1'b0, ctx_s2.imb});

	// Stage 4: apply to both bodies
	always_comb begin
		s0   = sat32(66'(ctx_s3.a_x) - 66'(max_s3 >>> 16));
		s1   = sat32(66'(ctx_s3.a_y) - 66'(may_s3 >>> 16));
		s2   = sat32(66'(ctx_s3.b_x) + 66'(mbx_s3 >>> 16));
		s3   = sat32(66'(ctx_s3.b_y) + 66'(mby_s3 >>> 16));
		ctx4 = ctx_s3;
		ctx4.clipped = ctx_s3.clipped | s0[32] | s1[32] | s2[32] | s3[32];
	end

	// Stage 5: bullet damping and final outcome
	always_comb begin
		dmp = $signed({17'd0, damping});
		res.new_a_x = ctx_s4.a_x;
		res.new_a_y = ctx_s4.a_y;
		res.new_b_x = ctx_s4.b_x;
		res.new_b_y = ctx_s4.b_y;
		res.outcome = ctx_s4.outcome;
		if (ctx_s4.outcome == OUT_APPLIED) begin
			if (ctx_s4.mode == MODE_IMPULSE && ctx_s4.bullet) begin
				res.new_a_x = 32'((49'(r0_s4) * 49'(dmp)) >>> 16);
				res.new_a_y = 32'((49'(r1_s4) * 49'(dmp)) >>> 16);
				res.new_b_x = 32'((49'(r2_s4) * 49'(dmp)) >>> 16);
				res.new_b_y = 32'((49'(r3_s4) * 49'(dmp)) >>> 16);
			end else begin
				res.new_a_x = r0_s4;
				res.new_a_y = r1_s4;
				res.new_b_x = r2_s4;
				res.new_b_y = r3_s4;
			end
			res.outcome = ctx_s4.clipped ? OUT_SATURATED : OUT_APPLIED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vin;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx1;
			pa_s1  <= 64'(din.ctx.nx) * 64'(j);
			pb_s1  <= 64'(din.ctx.ny) * 64'(j);
			ctx_s2 <= ctx2;
			ctx_s3 <= ctx_s2;
			max_s3 <= 64'(ctx_s2.vx) * 64'(ima_s);
			may_s3 <= 64'(ctx_s2.vy) * 64'(ima_s);
			mbx_s3 <= 64'(ctx_s2.vx) * 64'(imb_s);
			mby_s3 <= 64'(ctx_s2.vy) * 64'(imb_s);
			ctx_s4 <= ctx4;
			r0_s4  <= s0[31:0];
			r1_s4  <= s1[31:0];
			r2_s4  <= s2[31:0];
			r3_s4  <= s3[31:0];
			res_s5 <= res;
		end
	end

	assign vout = valid_s5;
	assign dout = res_s5;

endmodule
